// File: hdl/ihs_pkg.sv
// Shared constants and types for the inverse hyperbolic sine pipeline.
package ihs_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int RAD_W         = 64;
    localparam int SHIFT_W       = 5;
    localparam int SQRT_STEPS    = 32;
    localparam int LOG_BITS      = 32;
    localparam int LH_W          = 6;
    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    // Sideband that travels with the radicand through the square-root stages.
    typedef struct packed {
        logic        neg;
        logic [SHIFT_W-1:0] k;
        logic [WORD_W-1:0]  ak;
    } t_side;
endpackage

// File: hdl/inverse_hyperbolic_sine_top.sv
// Top level of the pipelined inverse hyperbolic sine unit.
//
// Usage: drive i_arg_value (signed Q15.16 by default) and pulse start.
// busy is always low, so an item is taken on every cycle that start is
// high; items may follow each other back to back.
// Each result appears on o_asinh_value for exactly one cycle, marked by
// o_valid, in the order taken. Throughput is one item per cycle. The pipeline
// is made of the square root (one result bit per stage, 32 stages) and the
// logarithm (one setup stage, then one fraction bit per stage, each a 32 by
// 32 squaring, 33 stages in all), plus 4 front-end and 3 back-end stages.
// There is no stored state between items. Reset clears the valid bits of
// every stage; results in flight are dropped.
// The receiver cannot stall the unit, so no back pressure is applied.
module inverse_hyperbolic_sine_top #(
    parameter int FRAC_BITS = ihs_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [ihs_pkg::WORD_W-1:0] i_arg_value,
    output logic                              o_valid,
    output logic signed [ihs_pkg::WORD_W-1:0] o_asinh_value
);
    import ihs_pkg::*;

    logic                fr_valid, sq_valid, lg_valid, lg_neg;
    logic [RAD_W-1:0]    fr_rad;
    t_side               fr_side, sq_side;
    logic [WORD_W-1:0]   sq_root, bk_value;
    logic [LH_W-1:0]     lg_lh;
    logic [LOG_BITS-1:0] lg_frac;

    assign busy = 1'b0;

    ihs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_arg   (i_arg_value),
        .o_valid (fr_valid),
        .o_rad   (fr_rad),
        .o_side  (fr_side)
    );

    ihs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .i_rad   (fr_rad),
        .i_side  (fr_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    ihs_log #(.FRAC_BITS(FRAC_BITS)) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_root  (sq_root),
        .i_side  (sq_side),
        .o_valid (lg_valid),
        .o_neg   (lg_neg),
        .o_lh    (lg_lh),
        .o_frac  (lg_frac)
    );

    ihs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lg_valid),
        .i_neg   (lg_neg),
        .i_lh    (lg_lh),
        .i_frac  (lg_frac),
        .o_valid (o_valid),
        .o_value (bk_value)
    );

    assign o_asinh_value = bk_value;
endmodule

// File: hdl/ihs_front.sv
// Front end: magnitude, radicand x*x + 1 and its even normalizing shift.
module ihs_front #(
    parameter int FRAC_BITS = ihs_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [ihs_pkg::WORD_W-1:0] i_arg,
    output logic                      o_valid,
    output logic [ihs_pkg::RAD_W-1:0]  o_rad,
    output ihs_pkg::t_side            o_side
);
    import ihs_pkg::*;

    localparam logic [RAD_W-1:0] ONE_SQ = RAD_W'(1) << (2 * FRAC_BITS);

    logic [3:0]              r_vld;
    logic [WORD_W-1:0]       r_a1, r_a2, r_a3;
    logic                    r_neg1, r_neg2, r_neg3, r_neg4;
    logic [RAD_W-1:0]        r_rad2, r_rad3, r_rad4;
    logic [SHIFT_W-1:0]      r_k3, r_k4;
    logic [WORD_W-1:0]       r_ak4;
    logic [SHIFT_W:0]        n_cnt;
    logic                    n_found;

    // Count leading all-zero bit pairs of the radicand.
    always_comb begin
        n_cnt   = '0;
        n_found = 1'b0;
        for (int j = 0; j < RAD_W / 2; j++) begin
            if (!n_found) begin
                if (r_rad2[RAD_W-1-2*j -: 2] == 2'b00) begin
                    n_cnt = n_cnt + 1'b1;
                end else begin
                    n_found = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
        r_neg1 <= i_arg[WORD_W-1];
        r_a1   <= i_arg[WORD_W-1] ? (~i_arg + 1'b1) : i_arg;

        r_neg2 <= r_neg1;
        r_a2   <= r_a1;
        r_rad2 <= RAD_W'(r_a1) * RAD_W'(r_a1) + ONE_SQ;

        r_neg3 <= r_neg2;
        r_a3   <= r_a2;
        r_rad3 <= r_rad2;
        r_k3   <= n_cnt[SHIFT_W-1:0];

        r_neg4 <= r_neg3;
        r_k4   <= r_k3;
        r_rad4 <= r_rad3 << {r_k3, 1'b0};
        r_ak4  <= r_a3 << r_k3;
    end

    assign o_valid     = r_vld[3];
    assign o_rad       = r_rad4;
    assign o_side.neg  = r_neg4;
    assign o_side.k    = r_k4;
    assign o_side.ak   = r_ak4;
endmodule

// File: hdl/ihs_sqrt.sv
// Integer square root, one result bit per pipeline stage.
module ihs_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [ihs_pkg::RAD_W-1:0]  i_rad,
    input  ihs_pkg::t_side             i_side,
    output logic                       o_valid,
    output logic [ihs_pkg::WORD_W-1:0] o_root,
    output ihs_pkg::t_side             o_side
);
    import ihs_pkg::*;

    logic             r_vld  [0:SQRT_STEPS];
    logic [RAD_W-1:0] r_v    [0:SQRT_STEPS];
    logic [RAD_W-1:0] r_r    [0:SQRT_STEPS];
    t_side            r_sd   [0:SQRT_STEPS];

    assign r_vld[0] = i_valid;
    assign r_v[0]   = i_rad;
    assign r_r[0]   = '0;
    assign r_sd[0]  = i_side;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * g);
        logic [RAD_W-1:0] n_trial;
        assign n_trial = r_r[g] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
            r_sd[g+1] <= r_sd[g];
            if (r_v[g] >= n_trial) begin
                r_v[g+1] <= r_v[g] - n_trial;
                r_r[g+1] <= (r_r[g] >> 1) + BIT;
            end else begin
                r_v[g+1] <= r_v[g];
                r_r[g+1] <= r_r[g] >> 1;
            end
        end
    end

    assign o_valid = r_vld[SQRT_STEPS];
    assign o_root  = r_r[SQRT_STEPS][WORD_W-1:0];
    assign o_side  = r_sd[SQRT_STEPS];
endmodule

// File: hdl/ihs_log.sv
// Base-2 logarithm of x + sqrt(x*x + 1) by repeated squaring, one bit a stage.
module ihs_log #(
    parameter int FRAC_BITS = ihs_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [ihs_pkg::WORD_W-1:0]  i_root,
    input  ihs_pkg::t_side              i_side,
    output logic                        o_valid,
    output logic                        o_neg,
    output logic [ihs_pkg::LH_W-1:0]    o_lh,
    output logic [ihs_pkg::LOG_BITS-1:0] o_frac
);
    import ihs_pkg::*;

    logic                y_vld;
    logic [WORD_W:0]     n_y;
    logic [LH_W:0]       n_e, n_sub;

    logic                r_vld  [0:LOG_BITS];
    logic                r_neg  [0:LOG_BITS];
    logic [LH_W-1:0]     r_lh   [0:LOG_BITS];
    logic [WORD_W-1:0]   r_m    [0:LOG_BITS];
    logic [LOG_BITS-1:0] r_frac [0:LOG_BITS];

    assign y_vld = i_valid;

    // The sum lies in [2^31, 2^33), so the top bit is bit 31 or bit 32.
    always_comb begin
        n_y   = (WORD_W+1)'(i_side.ak) + (WORD_W+1)'(i_root);
        n_e   = (LH_W+1)'(WORD_W - 1) + (LH_W+1)'(n_y[WORD_W]);
        n_sub = (LH_W+1)'(FRAC_BITS) + (LH_W+1)'(i_side.k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= y_vld;
        end
        r_neg[0]  <= i_side.neg;
        r_lh[0]   <= (n_e >= n_sub) ? LH_W'(n_e - n_sub) : '0;
        r_m[0]    <= n_y[WORD_W] ? n_y[WORD_W:1] : n_y[WORD_W-1:0];
        r_frac[0] <= '0;
    end

    for (genvar g = 0; g < LOG_BITS; g++) begin : g_bit
        logic [2*WORD_W-1:0] n_sq;
        logic [WORD_W:0]     n_q;
        assign n_sq = (2*WORD_W)'(r_m[g]) * (2*WORD_W)'(r_m[g]);
        // The square of a Q1.31 mantissa, cut back to 31 fraction bits as a Q2.31 value (33 bits).
        assign n_q  = n_sq[2*WORD_W-1 -: WORD_W+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
            r_neg[g+1]  <= r_neg[g];
            r_lh[g+1]   <= r_lh[g];
            r_m[g+1]    <= n_q[WORD_W] ? n_q[WORD_W:1] : n_q[WORD_W-1:0];
            r_frac[g+1] <= {r_frac[g][LOG_BITS-2:0], n_q[WORD_W]};
        end
    end

    assign o_valid = r_vld[LOG_BITS];
    assign o_neg   = r_neg[LOG_BITS];
    assign o_lh    = r_lh[LOG_BITS];
    assign o_frac  = r_frac[LOG_BITS];
endmodule

// File: hdl/ihs_back.sv
// Back end: scale by ln 2, round, saturate and restore the sign.
module ihs_back #(
    parameter int FRAC_BITS = ihs_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_neg,
    input  logic [ihs_pkg::LH_W-1:0]     i_lh,
    input  logic [ihs_pkg::LOG_BITS-1:0] i_frac,
    output logic                         o_valid,
    output logic [ihs_pkg::WORD_W-1:0]   o_value
);
    import ihs_pkg::*;

    localparam int PH_W = LH_W + 32;
    localparam logic [63:0] HALF = 64'(1) << (31 - FRAC_BITS);

    logic [2:0]        r_vld;
    logic              r_neg1, r_neg2;
    logic [PH_W-1:0]   r_ph;
    logic [63:0]       r_pl;
    logic [63:0]       r_mag;
    logic [WORD_W-1:0] r_out;
    logic [63:0]       n_t, n_mag;
    logic [WORD_W-1:0] n_sat;

    always_comb begin
        n_t   = 64'(r_ph) + (r_pl >> 32);
        n_mag = (n_t + HALF) >> (32 - FRAC_BITS);
        n_sat = (|r_mag[63:WORD_W-1]) ? {1'b0, {(WORD_W-1){1'b1}}} : r_mag[WORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
        r_neg1 <= i_neg;
        r_ph   <= PH_W'(i_lh) * PH_W'(LN2_Q32);
        r_pl   <= 64'(i_frac) * 64'(LN2_Q32);

        r_neg2 <= r_neg1;
        r_mag  <= n_mag;

        r_out  <= r_neg2 ? (~n_sat + 1'b1) : n_sat;
    end

    assign o_valid = r_vld[2];
    assign o_value = r_out;
endmodule
